// ----- rtl/rcia_pkg.sv -----
// Package: types, constants and helpers for the refcounted identifier allocator.
package rcia_pkg;

	localparam int ID_COUNT    = 256;
	localparam int COUNT_WIDTH = 16;

	localparam int ID_W      = $clog2(ID_COUNT);
	localparam int FUNC_W    = 3;
	localparam int ID_IN_W   = 8;
	localparam int REF_W     = 16;
	localparam int STATUS_W  = 3;

	// free-slot search: groups of GRP identifiers, one registered free flag and index per group
	localparam int GRP    = 16;
	localparam int GRP_W  = $clog2(GRP);
	localparam int N_GRP  = (ID_COUNT + GRP - 1) / GRP;
	localparam int NGRP_W = (N_GRP > 1) ? $clog2(N_GRP) : 1;
	localparam int FND_W  = NGRP_W + GRP_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC   = 3'd0,
		FN_RETAIN  = 3'd1,
		FN_RELEASE = 3'd2,
		FN_QUERY   = 3'd3,
		FN_CLEAR   = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_UNINIT   = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ID_IN_W-1:0] id;
	} req_t;

	typedef struct packed {
		logic [ID_IN_W-1:0]  id_out;
		logic [REF_W-1:0]    ref_count;
		logic                present;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic load;    // latch request, launch count read
		logic scan;    // register group-level free search
		logic commit;  // update state, load response register
	} ctl_cmd_t;

	function automatic logic [GRP_W-1:0] first_set(input logic [GRP-1:0] v);
		logic [GRP_W-1:0] r;
		r = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (v[i]) r = GRP_W'(i);
		end
		return r;
	endfunction

endpackage

// ----- rtl/refcounted_id_allocator_top.sv -----
// Top level: refcounted identifier allocator.
//
//   channel   signals                      direction   payload
//   request   req_valid / req_stall / req  in          rcia_pkg::req_t (func, id)
//   response  rsp_valid / rsp_stall / rsp  out         rcia_pkg::rsp_t
//   config    cfg_we / cfg_wdata           in          enable bit
//
// Each transaction steps through accept with count RAM read, then the group-level free
// search registered, then commit of the read-modify-write and the response.
// The count RAM's single port pair and registered read set that sequence.
// Reset clears enable and every live bit; the count RAM is not cleared.
// A stalled response holds commit in its last state until the slot frees.
module refcounted_id_allocator_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           req_valid,
	output logic           req_stall,
	input  rcia_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rcia_pkg::rsp_t rsp
);
	import rcia_pkg::*;

	ctl_cmd_t cmd;

	rcia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd      (cmd)
	);

	rcia_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.req      (req),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(rsp_valid && rsp_stall))
		else $error("commit into an occupied response slot");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous transaction in flight");

	a_present_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.present) |-> (rsp.status == ST_OK || rsp.status == ST_OVERFLOW))
		else $error("present set with failing status");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan, cmd.commit}))
		else $error("overlapping datapath commands");
`endif

endmodule

// ----- rtl/rcia_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rcia_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/rcia_ctrl.sv -----
// Controller: sequences load, scan and commit for each transaction.
module rcia_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rcia_pkg::ctl_cmd_t cmd
);
	import rcia_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.scan = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/rcia_dp.sv -----
// Datapath: live map, count RAM, free-slot search and response register.
module rcia_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  rcia_pkg::ctl_cmd_t cmd,
	input  rcia_pkg::req_t     req,
	output rcia_pkg::rsp_t     rsp
);
	import rcia_pkg::*;

	logic                   enable_q;
	logic [ID_COUNT-1:0]    live_q;
	req_t                   req_q;
	rsp_t                   rsp_q;
	logic [N_GRP-1:0]       grp_free_s1;
	logic [GRP_W-1:0]       grp_idx_s1 [N_GRP];

	logic [N_GRP*GRP-1:0]   free_pad;
	logic                   any_free;
	logic [FND_W-1:0]       found_full;
	logic [ID_W-1:0]        found;
	logic [ID_W-1:0]        idx;
	logic                   in_range;
	logic                   live;
	logic [COUNT_WIDTH-1:0] cnt;
	logic [COUNT_WIDTH-1:0] cnt_max;

	logic                   ram_we;
	logic [ID_W-1:0]        ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic                   set_live, clr_one, clr_all;
	rsp_t                   rsp_d;

	assign cnt_max  = '1;
	assign idx      = ID_W'(req_q.id);
	assign in_range = (32'(req_q.id) < ID_COUNT);
	assign live     = in_range && live_q[idx];

	rcia_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(ID_COUNT)
	) u_cnt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.load),
		.raddr(ID_W'(req.id)),
		.rdata(cnt)
	);

	always_comb begin
		free_pad = '0;
		free_pad[ID_COUNT-1:0] = ~live_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.scan) begin
			for (int g = 0; g < N_GRP; g++) begin
				grp_free_s1[g] <= |free_pad[g*GRP +: GRP];
				grp_idx_s1[g]  <= first_set(free_pad[g*GRP +: GRP]);
			end
		end
		if (cmd.commit) rsp_q <= rsp_d;
	end

	always_comb begin
		any_free   = 1'b0;
		found_full = '0;
		for (int g = N_GRP - 1; g >= 0; g--) begin
			if (grp_free_s1[g]) begin
				any_free   = 1'b1;
				found_full = FND_W'(g * GRP) + FND_W'(grp_idx_s1[g]);
			end
		end
		found = ID_W'(found_full);
	end

	always_comb begin
		rsp_d     = '{id_out: req_q.id, ref_count: '0, present: 1'b0, status: ST_NOTFOUND};
		ram_we    = 1'b0;
		ram_waddr = idx;
		ram_wdata = cnt;
		set_live  = 1'b0;
		clr_one   = 1'b0;
		clr_all   = 1'b0;
		if (!enable_q) begin
			rsp_d.status = ST_UNINIT;
		end else begin
			unique case (req_q.func)
				FN_ALLOC: begin
					if (any_free) begin
						rsp_d     = '{id_out: ID_IN_W'(found), ref_count: REF_W'(1),
						              present: 1'b1, status: ST_OK};
						ram_we    = 1'b1;
						ram_waddr = found;
						ram_wdata = COUNT_WIDTH'(1);
						set_live  = 1'b1;
					end else begin
						rsp_d = '{id_out: '0, ref_count: '0, present: 1'b0, status: ST_FULL};
					end
				end
				FN_RETAIN: begin
					if (live && cnt == cnt_max) begin
						rsp_d.ref_count = REF_W'(cnt);
						rsp_d.present   = 1'b1;
						rsp_d.status    = ST_OVERFLOW;
					end else if (live) begin
						ram_we          = 1'b1;
						ram_wdata       = cnt + COUNT_WIDTH'(1);
						rsp_d.ref_count = REF_W'(cnt + COUNT_WIDTH'(1));
						rsp_d.present   = 1'b1;
						rsp_d.status    = ST_OK;
					end
				end
				FN_RELEASE: begin
					if (live && cnt <= COUNT_WIDTH'(1)) begin
						clr_one      = 1'b1;
						rsp_d.status = ST_OK;
					end else if (live) begin
						ram_we          = 1'b1;
						ram_wdata       = cnt - COUNT_WIDTH'(1);
						rsp_d.ref_count = REF_W'(cnt - COUNT_WIDTH'(1));
						rsp_d.present   = 1'b1;
						rsp_d.status    = ST_OK;
					end
				end
				FN_QUERY: begin
					if (live) begin
						rsp_d.ref_count = REF_W'(cnt);
						rsp_d.present   = 1'b1;
						rsp_d.status    = ST_OK;
					end
				end
				FN_CLEAR: begin
					clr_all = 1'b1;
					rsp_d   = '{id_out: '0, ref_count: '0, present: 1'b0, status: ST_OK};
				end
				default: ;
			endcase
		end
		if (!cmd.commit) begin
			ram_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			live_q   <= '0;
		end else begin
			if (cfg_we) enable_q <= cfg_wdata;
			if (cfg_we && !cfg_wdata) begin
				live_q <= '0;
			end else if (cmd.commit) begin
				if (clr_all) live_q <= '0;
				else if (set_live) live_q[found] <= 1'b1;
				else if (clr_one) live_q[idx] <= 1'b0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- dv/refcounted_id_allocator_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for refcounted_id_allocator_top: directed and random requests against a shadow model.
module refcounted_id_allocator_top_tb;
	import rcia_pkg::*;

	localparam int SETTLE_CYC = 6;
	localparam int HOLD_CYC   = 120;
	localparam int CALM_TAIL  = 100;
	localparam int TAIL_CYC   = 20;
	localparam int WDOG_LIMIT = 2000;

	typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_DRAIN, STEP_HOLD} step_kind_t;

	typedef struct {
		step_kind_t kind;
		req_t       req;
		logic       val;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic calm = 1'b0;
	logic hold_kick = 1'b0;

	step_t stim_q[$];
	rsp_t  rsp_expect_q[$];

	logic             shadow_enable = 1'b0;
	logic [ID_COUNT-1:0] shadow_live = '0;
	logic [REF_W-1:0] shadow_count [ID_COUNT];

	int n_err = 0;
	int n_sent = 0;
	int n_recv = 0;
	int settle = 0;
	int gap_left = 0;
	int hold_left = 0;
	int run_left = 0;
	int stuck = 0;

	refcounted_id_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0d, expected %0d", what, seen, want);
		n_err++;
	endtask

	function automatic void queue_op(input logic [FUNC_W-1:0] f, input logic [ID_IN_W-1:0] i);
		step_t s;
		s.kind = STEP_REQ;
		s.req.func = f;
		s.req.id = i;
		s.val = 1'b0;
		stim_q.push_back(s);
	endfunction

	function automatic void queue_step(input step_kind_t k, input logic v);
		step_t s;
		s.kind = k;
		s.req = '0;
		s.val = v;
		stim_q.push_back(s);
	endfunction

	task automatic queue_random(input int n);
		int w;
		logic [FUNC_W-1:0] f;
		logic [ID_IN_W-1:0] i;
		for (int k = 0; k < n; k++) begin
			w = $urandom_range(0, 99);
			if (w < 30) f = FN_ALLOC;
			else if (w < 50) f = FN_RETAIN;
			else if (w < 75) f = FN_RELEASE;
			else if (w < 90) f = FN_QUERY;
			else if (w < 93) f = FN_CLEAR;
			else f = FUNC_W'($urandom_range(5, 7));
			if ($urandom_range(0, 3) != 0) i = ID_IN_W'($urandom_range(0, 23));
			else i = ID_IN_W'($urandom_range(0, 255));
			queue_op(f, i);
		end
	endtask

	function automatic rsp_t refcount_predict(input req_t r);
		rsp_t o;
		logic found;
		o.id_out = r.id;
		o.ref_count = '0;
		o.present = 1'b0;
		o.status = ST_NOTFOUND;
		if (!shadow_enable) begin
			o.status = ST_UNINIT;
			return o;
		end
		case (r.func)
		FN_ALLOC: begin
			o.id_out = '0;
			o.status = ST_FULL;
			found = 1'b0;
			for (int i = 0; i < ID_COUNT; i++) begin
				if (!found && !shadow_live[i]) begin
					found = 1'b1;
					shadow_live[i] = 1'b1;
					shadow_count[i] = REF_W'(1);
					o.id_out = ID_IN_W'(i);
					o.ref_count = REF_W'(1);
					o.present = 1'b1;
					o.status = ST_OK;
				end
			end
		end
		FN_RETAIN: begin
			if (shadow_live[r.id]) begin
				o.present = 1'b1;
				if (shadow_count[r.id] == '1) begin
					o.status = ST_OVERFLOW;
				end else begin
					shadow_count[r.id] = shadow_count[r.id] + 1'b1;
					o.status = ST_OK;
				end
				o.ref_count = shadow_count[r.id];
			end
		end
		FN_RELEASE: begin
			if (shadow_live[r.id]) begin
				o.status = ST_OK;
				if (shadow_count[r.id] <= 1) begin
					shadow_live[r.id] = 1'b0;
				end else begin
					shadow_count[r.id] = shadow_count[r.id] - 1'b1;
					o.ref_count = shadow_count[r.id];
					o.present = 1'b1;
				end
			end
		end
		FN_QUERY: begin
			if (shadow_live[r.id]) begin
				o.ref_count = shadow_count[r.id];
				o.present = 1'b1;
				o.status = ST_OK;
			end
		end
		FN_CLEAR: begin
			shadow_live = '0;
			o.id_out = '0;
			o.status = ST_OK;
		end
		default: ;
		endcase
		return o;
	endfunction

	// driver: request channel, config writes, pauses
	always @(posedge clk or negedge arst_n) begin
		logic v_n;
		logic we_n;
		logic wd_n;
		logic kick_n;
		req_t r_n;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= 1'b0;
			hold_kick <= 1'b0;
			calm <= 1'b0;
		end else begin
			v_n = req_valid;
			r_n = req;
			we_n = 1'b0;
			wd_n = cfg_wdata;
			kick_n = 1'b0;
			if (req_valid && !req_stall) begin
				n_sent++;
				v_n = 1'b0;
			end
			if (rsp_valid && !rsp_stall)
				n_recv++;
			if (n_sent == n_recv && !v_n && !cfg_we) settle++;
			else settle = 0;
			if (!v_n && !cfg_we && stim_q.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					case (stim_q[0].kind)
					STEP_REQ: begin
						v_n = 1'b1;
						r_n = stim_q[0].req;
						void'(stim_q.pop_front());
						if (!calm && $urandom_range(0, 7) == 0)
							gap_left = $urandom_range(1, 12);
					end
					STEP_CFG: if (settle >= SETTLE_CYC) begin
						we_n = 1'b1;
						wd_n = stim_q[0].val;
						void'(stim_q.pop_front());
					end
					STEP_DRAIN: if (n_sent == n_recv) void'(stim_q.pop_front());
					STEP_HOLD: begin
						kick_n = 1'b1;
						void'(stim_q.pop_front());
					end
					endcase
				end
			end
			req_valid <= v_n;
			req <= r_n;
			cfg_we <= we_n;
			cfg_wdata <= wd_n;
			hold_kick <= kick_n;
			calm <= (stim_q.size() < CALM_TAIL);
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (hold_kick) begin
				hold_left = HOLD_CYC;
				run_left = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (calm) begin
				rsp_stall <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
			end else if (!rsp_stall && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				run_left = $urandom_range(0, 11);
			end else begin
				rsp_stall <= 1'b0;
				run_left = $urandom_range(0, 20);
			end
		end
	end

	// monitor: shadow model update and response check
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (cfg_we) begin
				shadow_enable = cfg_wdata;
				if (!cfg_wdata) shadow_live = '0;
			end
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expect_q.size() == 0) begin
					flag_mismatch("transaction with nothing pending, id_out",
						32'(rsp.id_out), 0);
				end else begin
					want = rsp_expect_q.pop_front();
					if (rsp.id_out !== want.id_out)
						flag_mismatch("id_out", 32'(rsp.id_out), 32'(want.id_out));
					if (rsp.ref_count !== want.ref_count)
						flag_mismatch("ref_count", 32'(rsp.ref_count), 32'(want.ref_count));
					if (rsp.present !== want.present)
						flag_mismatch("present", 32'(rsp.present), 32'(want.present));
					if (rsp.status !== want.status)
						flag_mismatch("status", 32'(rsp.status), 32'(want.status));
				end
			end
			if (req_valid && !req_stall)
				rsp_expect_q.push_back(refcount_predict(req));
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) stuck = 0;
			else stuck++;
			if (stuck >= WDOG_LIMIT) begin
				$display("refcounted_id_allocator_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		// disabled: everything reports uninitialized
		queue_op(FN_ALLOC, 8'h00);
		queue_op(FN_RETAIN, 8'h00);
		queue_op(FN_RELEASE, 8'hff);
		queue_op(FN_QUERY, 8'haa);
		queue_op(FN_CLEAR, 8'h55);
		queue_op(3'd7, 8'h55);
		queue_step(STEP_CFG, 1'b1);
		queue_op(FN_ALLOC, 8'hff);
		queue_op(FN_RETAIN, 8'h00);
		queue_op(FN_QUERY, 8'h00);
		queue_op(FN_RELEASE, 8'h00);
		queue_op(FN_RELEASE, 8'h00);
		queue_op(FN_RELEASE, 8'h00);
		queue_op(FN_RETAIN, 8'hff);
		queue_op(FN_QUERY, 8'hff);
		queue_op(3'd5, 8'h0f);
		queue_op(3'd6, 8'hf0);
		queue_op(3'd7, 8'hff);
		queue_op(FN_ALLOC, 8'h00);
		queue_op(FN_CLEAR, 8'haa);
		queue_op(FN_QUERY, 8'h00);
		// fill every identifier, then one more allocate hits full
		for (int k = 0; k <= ID_COUNT; k++)
			queue_op(FN_ALLOC, ID_IN_W'(k));
		queue_op(FN_QUERY, 8'hff);
		queue_op(FN_RELEASE, 8'h80);
		queue_op(FN_ALLOC, 8'h00);
		queue_op(FN_CLEAR, 8'h00);
		queue_op(FN_ALLOC, 8'h00);
		queue_op(FN_RETAIN, 8'h00);
		queue_op(FN_QUERY, 8'h00);
		queue_op(FN_RELEASE, 8'h00);
		queue_op(FN_ALLOC, 8'h00);
		// disabling frees everything
		queue_step(STEP_CFG, 1'b0);
		queue_op(FN_QUERY, 8'h00);
		queue_step(STEP_CFG, 1'b0);
		queue_step(STEP_CFG, 1'b1);
		queue_op(FN_QUERY, 8'h00);
		queue_op(FN_QUERY, 8'h01);

		queue_random(60);
		queue_step(STEP_CFG, 1'b1);
		queue_step(STEP_HOLD, 1'b0);
		queue_random(60);
		queue_step(STEP_CFG, 1'b0);
		queue_random(12);
		queue_step(STEP_CFG, 1'b1);
		queue_random(40);
		queue_step(STEP_DRAIN, 1'b0);
		queue_random(40);
		queue_step(STEP_HOLD, 1'b0);
		queue_random(104);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (stim_q.size() > 0 || req_valid || n_sent != n_recv)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (rsp_expect_q.size() != 0)
			flag_mismatch("results never delivered", rsp_expect_q.size(), 0);
		if (n_err == 0)
			$display("refcounted_id_allocator_top regression: pass");
		else
			$display("refcounted_id_allocator_top regression: fail");
		$finish;
	end

endmodule
